/* rtl/wvsd_pkg.sv */
// Package: shared types, constants and the arctangent table for the wind vector converter.
`timescale 1ns / 1ps
package wvsd_pkg;

  // Number of rotation steps in the angle chain
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_STEPS    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  // Digit steps of the square root of a 32-bit sum of squares
  localparam int SQRT_STEPS    = 16;
  localparam int NUM_CELLS     = (ATAN_STEPS > SQRT_STEPS) ? ATAN_STEPS : SQRT_STEPS;
  localparam int IDX_W         = $clog2(NUM_CELLS);

  // Datapath widths
  localparam int XW = 43;  // rotation x / y, |u| << 24 grown by gain and sqrt(2)
  localparam int ZW = 25;  // accumulated angle, 2^-16 degree
  localparam int DW = 27;  // meteorological angle before wrap

  // Angle constants in 2^-16 degree
  localparam logic signed [ZW-1:0] THETA_MAX = ZW'(90 * 65536);
  localparam logic signed [DW-1:0] DEG_180   = DW'(180 * 65536);
  localparam logic signed [DW-1:0] DEG_270   = DW'(270 * 65536);
  localparam logic signed [DW-1:0] DEG_360   = DW'(360 * 65536);
  localparam logic signed [DW-1:0] DIR_ROUND = DW'(512);

  // Input word
  typedef struct packed {
    logic signed [15:0] east_component;
    logic signed [15:0] north_component;
    logic               east_missing;
    logic               north_missing;
  } wvsd_in_t;

  // Result word
  typedef struct packed {
    logic [15:0] wind_speed;
    logic [14:0] wind_direction;
    logic        result_valid;
  } wvsd_out_t;

  // State carried from cell to cell
  typedef struct packed {
    logic [31:0]          rem;
    logic [31:0]          root;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 u_neg;
    logic                 v_neg;
    logic                 missing;
  } wvsd_cell_t;

  // round(atan(2^-i) in degrees * 65536)
  function automatic logic signed [ZW-1:0] atan_angle(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:    a = ZW'(2949120);
      5'd1:    a = ZW'(1740967);
      5'd2:    a = ZW'(919879);
      5'd3:    a = ZW'(466945);
      5'd4:    a = ZW'(234379);
      5'd5:    a = ZW'(117304);
      5'd6:    a = ZW'(58666);
      5'd7:    a = ZW'(29335);
      5'd8:    a = ZW'(14668);
      5'd9:    a = ZW'(7334);
      5'd10:   a = ZW'(3667);
      5'd11:   a = ZW'(1833);
      5'd12:   a = ZW'(917);
      5'd13:   a = ZW'(458);
      5'd14:   a = ZW'(229);
      5'd15:   a = ZW'(115);
      5'd16:   a = ZW'(57);
      5'd17:   a = ZW'(29);
      5'd18:   a = ZW'(14);
      5'd19:   a = ZW'(7);
      5'd20:   a = ZW'(4);
      5'd21:   a = ZW'(2);
      5'd22:   a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/wvsd_front.sv */
// Front end: absolute values, squares and the seed word for the cell chain.
`timescale 1ns / 1ps
module wvsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  wvsd_pkg::wvsd_in_t   data_i,
  output logic                 valid_o,
  output wvsd_pkg::wvsd_cell_t data_o
);
  import wvsd_pkg::*;

  logic [16:0] ax_d, ay_d, ax_q, ay_q;
  logic [16:0] u_ext, v_ext;
  logic [33:0] prod_u, prod_v;
  logic [31:0] squ_q, sqv_q;
  logic        uneg_q, vneg_q, miss_q, v1_q;
  logic        valid_q;
  wvsd_cell_t  seed_d, seed_q;

  // Take magnitudes in 17 bits so the most negative value folds cleanly
  always_comb begin
    u_ext  = {data_i.east_component[15], data_i.east_component};
    v_ext  = {data_i.north_component[15], data_i.north_component};
    ax_d   = u_ext[16] ? (17'd0 - u_ext) : u_ext;
    ay_d   = v_ext[16] ? (17'd0 - v_ext) : v_ext;
    prod_u = ax_d * ax_d;
    prod_v = ay_d * ay_d;
  end

  // Stage one: register squares and signs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      squ_q  <= prod_u[31:0];
      sqv_q  <= prod_v[31:0];
      uneg_q <= data_i.east_component[15];
      vneg_q <= data_i.north_component[15];
      miss_q <= data_i.east_missing | data_i.north_missing;
    end
  end

  // Stage two: sum of squares and rotation seed
  always_comb begin
    seed_d.rem     = squ_q + sqv_q;
    seed_d.root    = '0;
    seed_d.x       = XW'({ax_q, 24'd0});
    seed_d.y       = XW'({ay_q, 24'd0});
    seed_d.z       = '0;
    seed_d.u_neg   = uneg_q;
    seed_d.v_neg   = vneg_q;
    seed_d.missing = miss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      seed_q <= seed_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = seed_q;

endmodule

/* rtl/wvsd_cell.sv */
// Chain cell: one square root digit and one rotation step per cycle while adv_i is high.
`timescale 1ns / 1ps
module wvsd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [wvsd_pkg::IDX_W-1:0] stage_i,
  input  logic                 valid_i,
  input  wvsd_pkg::wvsd_cell_t data_i,
  output logic                 valid_o,
  output wvsd_pkg::wvsd_cell_t data_o
);
  import wvsd_pkg::*;

  logic                 sqrt_on, rot_on;
  logic [4:0]           bit_sh;
  logic [31:0]          sq_bit, trial;
  logic signed [XW-1:0] dx, dy;
  logic                 y_pos;
  logic signed [ZW-1:0] ang;
  wvsd_cell_t           cell_d, cell_q;
  logic                 valid_q;

  always_comb begin
    sqrt_on = (int'(stage_i) < SQRT_STEPS);
    rot_on  = (int'(stage_i) < ATAN_STEPS);
    bit_sh  = sqrt_on ? 5'(2 * (SQRT_STEPS - 1 - int'(stage_i))) : 5'd0;
    sq_bit  = 32'd1 << bit_sh;
    trial   = data_i.root + sq_bit;
    dx      = data_i.y >>> stage_i;
    dy      = data_i.x >>> stage_i;
    y_pos   = !data_i.y[XW-1] && (data_i.y != '0);
    ang     = atan_angle(5'(stage_i));
    cell_d  = data_i;

    // Resolve one root digit
    if (sqrt_on) begin
      if (data_i.rem >= trial) begin
        cell_d.rem  = data_i.rem - trial;
        cell_d.root = (data_i.root >> 1) + sq_bit;
      end else begin
        cell_d.root = data_i.root >> 1;
      end
    end

    // Rotate toward the x axis
    if (rot_on) begin
      if (y_pos) begin
        cell_d.x = data_i.x + dx;
        cell_d.y = data_i.y - dy;
        cell_d.z = data_i.z + ang;
      end else begin
        cell_d.x = data_i.x - dx;
        cell_d.y = data_i.y + dy;
        cell_d.z = data_i.z - ang;
      end
    end
  end

  // Hand the word to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = cell_q;

endmodule

/* rtl/wvsd_back.sv */
// Back end: speed rounding, quadrant unfold, wrap, calm and missing masking.
`timescale 1ns / 1ps
module wvsd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [7:0]           calm_i,
  input  logic                 valid_i,
  input  wvsd_pkg::wvsd_cell_t data_i,
  output logic                 valid_o,
  output wvsd_pkg::wvsd_out_t  data_o
);
  import wvsd_pkg::*;

  logic [15:0]          speed_d, speed_q;
  logic signed [ZW-1:0] theta;
  logic signed [DW-1:0] theta_w, ang_a, dpre_d, dpre_q;
  logic                 miss_q, b1_valid_q;
  logic signed [DW-1:0] d_wrap, d_rnd;
  wvsd_out_t            out_d, out_q;
  logic                 out_valid_q;

  // Round the root and unfold the first-quadrant angle
  always_comb begin
    speed_d = data_i.root[15:0] + 16'(data_i.rem > data_i.root);
    if (data_i.z[ZW-1]) begin
      theta = '0;
    end else if (data_i.z > THETA_MAX) begin
      theta = THETA_MAX;
    end else begin
      theta = data_i.z;
    end
    theta_w = DW'(theta);
    unique case ({data_i.u_neg, data_i.v_neg})
      2'b00:   ang_a = theta_w;
      2'b01:   ang_a = -theta_w;
      2'b10:   ang_a = DEG_180 - theta_w;
      default: ang_a = theta_w - DEG_180;
    endcase
    dpre_d = DEG_270 - ang_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (adv_i) begin
      b1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      speed_q <= speed_d;
      dpre_q  <= dpre_d;
      miss_q  <= data_i.missing;
    end
  end

  // Wrap past north, round to 1/64 degree, apply calm and missing rules
  always_comb begin
    d_wrap = (dpre_q > DEG_360) ? (dpre_q - DEG_360) : dpre_q;
    d_rnd  = d_wrap + DIR_ROUND;
    out_d.result_valid = !miss_q;
    if (miss_q) begin
      out_d.wind_speed     = '0;
      out_d.wind_direction = '0;
    end else begin
      out_d.wind_speed     = speed_q;
      out_d.wind_direction = (speed_q > 16'(calm_i)) ? d_rnd[24:10] : 15'd0;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

/* rtl/wind_vector_to_speed_direction.sv */
// Top level: wind vector to speed and meteorological direction pipeline.
`timescale 1ns / 1ps
// Usage
//   Input channel in_valid_i / in_ready_o carries one word with the east and
//   north components (signed, 1/256 m/s) and their missing flags. Output
//   channel out_valid_o / out_ready_i returns one word per input word: speed
//   (1/256 m/s), direction the wind comes from (1/64 degree) and a valid flag.
//   The calm threshold is written through cfg_valid_i / cfg_data_i; the port
//   is always ready.
// Timing
//   One word enters every cycle while the receiver does not stall. The
//   pipeline has two front stages, one cell per square root digit and
//   rotation step, and two back stages. The cell chain length, the larger
//   of the 16 root digits and the rotation steps, sets the latency.
// Reset and stall
//   Reset empties the pipeline and clears the calm threshold to zero.
//   A stalled receiver freezes the whole pipeline; in_ready_o stays high as
//   long as the output register is empty or being drained.
module wind_vector_to_speed_direction (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wvsd_pkg::wvsd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wvsd_pkg::wvsd_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import wvsd_pkg::*;

  logic       adv;
  logic [7:0] calm_q;
  logic       chain_valid [NUM_CELLS+1];
  wvsd_cell_t chain_data  [NUM_CELLS+1];

  // Advance everything unless a finished word is waiting
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // Calm threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calm_q <= '0;
    end else if (cfg_valid_i) begin
      calm_q <= cfg_data_i;
    end
  end

  wvsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  // Cell chain
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    wvsd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (IDX_W'(g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  wvsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .calm_i  (calm_q),
    .valid_i (chain_valid[NUM_CELLS]),
    .data_i  (chain_data[NUM_CELLS]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // A missing component yields an all-zero result
  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.result_valid |->
      out_data_o.wind_speed == 16'd0 && out_data_o.wind_direction == 15'd0)
    else $error("missing word carries nonzero speed or direction");

  // Direction stays within a full turn
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.wind_direction <= 15'd23040)
    else $error("direction beyond 360 degrees");

  // Calm wind has no direction
  a_calm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.wind_speed <= 16'(calm_q) |->
      out_data_o.wind_direction == 15'd0)
    else $error("calm word carries a direction");

  // Speed never exceeds the largest possible magnitude
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.wind_speed <= 16'd46341)
    else $error("speed out of range");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no waiting result");

endmodule
